// ===== rtl/core/three_axis_rate_pid_top_macros.svh =====
// ============================================================================
// Rate PID assertion macros
// Shared property templates for the rate PID checkers.
// ============================================================================
`ifndef THREE_AXIS_RATE_PID_TOP_MACROS_SVH
`define THREE_AXIS_RATE_PID_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RPID_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RPID_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rpid_pkg.sv =====
// ============================================================================
// Rate PID package
// Field widths, register indexes, divider constants and shared types.
// ============================================================================
package rpid_pkg;

    localparam int NUM_AXES_MAX = 3;
    localparam int NUM_REGS     = 5;
    localparam int FIELD_W      = 16;
    localparam int REG_W        = NUM_AXES_MAX * FIELD_W;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_DATA_W    = 10 * FIELD_W;
    localparam int IN_USER_W    = 7;
    localparam int OUT_DATA_W   = 2 * NUM_AXES_MAX * FIELD_W;
    localparam int MUL_A_W      = 34;
    localparam int MUL_B_W      = 18;
    localparam int PROD_W       = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] REG_PROP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FFWD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 3'd4;

    // Rate limit in Q5.10, its square, and floor(2^42 / square)
    localparam logic [16:0] RATE_LIM    = 17'd7149;
    localparam logic [25:0] RATE_LIM_SQ = 26'd51108201;
    localparam logic [16:0] RECIP_K     = 17'd86053;

    typedef struct packed {
        logic [FIELD_W-1:0] prop;
        logic [FIELD_W-1:0] integ;
        logic [FIELD_W-1:0] deriv;
        logic [FIELD_W-1:0] ffwd;
        logic [FIELD_W-1:0] limit;
    } t_gains;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_op;

    function automatic logic signed [FIELD_W-1:0] sat16(input logic signed [30:0] x);
        logic signed [FIELD_W-1:0] y;
        if (x > 31'sd32767) begin
            y = 16'sh7fff;
        end else if (x < -31'sd32768) begin
            y = 16'sh8000;
        end else begin
            y = x[FIELD_W-1:0];
        end
        return y;
    endfunction

endpackage

// ===== rtl/core/rpid_cfg.sv =====
// ============================================================================
// Rate PID gain registers
// Five packed gain and limit registers with per-axis field select.
// ============================================================================
module rpid_cfg #(
    parameter int AXES = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr_en,
    input  logic [rpid_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  logic [rpid_pkg::REG_W-1:0]      i_wr_data,
    input  logic [((AXES > 1) ? $clog2(AXES) : 1)-1:0] i_axis,
    output rpid_pkg::t_gains                o_gains
);
    import rpid_pkg::*;

    logic [REG_W-1:0] r_prop;
    logic [REG_W-1:0] r_integ;
    logic [REG_W-1:0] r_deriv;
    logic [REG_W-1:0] r_ffwd;
    logic [REG_W-1:0] r_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop  <= '0;
            r_integ <= '0;
            r_deriv <= '0;
            r_ffwd  <= '0;
            r_limit <= '0;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                REG_PROP:  r_prop  <= i_wr_data;
                REG_INTEG: r_integ <= i_wr_data;
                REG_DERIV: r_deriv <= i_wr_data;
                REG_FFWD:  r_ffwd  <= i_wr_data;
                REG_LIMIT: r_limit <= i_wr_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_gains.prop  = r_prop[FIELD_W*i_axis +: FIELD_W];
        o_gains.integ = r_integ[FIELD_W*i_axis +: FIELD_W];
        o_gains.deriv = r_deriv[FIELD_W*i_axis +: FIELD_W];
        o_gains.ffwd  = r_ffwd[FIELD_W*i_axis +: FIELD_W];
        o_gains.limit = r_limit[FIELD_W*i_axis +: FIELD_W];
    end

endmodule

// ===== rtl/core/rpid_mul.sv =====
// ============================================================================
// Rate PID shared multiplier
// Signed 34x18 multiplier with a registered product.
// ============================================================================
module rpid_mul (
    input  logic                                    i_clk,
    input  rpid_pkg::t_mul_op                       i_op,
    output logic signed [rpid_pkg::PROD_W-1:0]      o_prod
);
    import rpid_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op.a * i_op.b;
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/core/three_axis_rate_pid_top.sv =====
// ============================================================================
// Three-axis rate PID
// PID with feedforward and integral anti-windup, one axis after another
// through a single shared multiplier.
// ============================================================================
// channel   direction  handshake                          payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata 160b, tuser 7b
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata 96b
// cfg       in         i_cfg_valid / o_cfg_ready          index 3b, data 48b
//
// From accept to result, one word passes through eleven steps per axis in
// the one registered 34x18 multiplier.
// Input ready is high only while no word is in work; a finished result waits
// in the output register while the next word is accepted.
// Reset clears the integrals, gains and handshake state; no clearing pass.
// ============================================================================
module three_axis_rate_pid_top #(
    parameter int AXES = 3
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // roll_rate, pitch_rate, yaw_rate, roll_target, pitch_target, yaw_target,
    // roll_accel, pitch_accel, yaw_accel, step_time
    input  logic [rpid_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // on_ground, limit_flags
    input  logic [rpid_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // roll_drive, pitch_drive, yaw_drive, roll_integral, pitch_integral,
    // yaw_integral
    output logic [rpid_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rpid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rpid_pkg::REG_W-1:0]        i_cfg_data
);
    import rpid_pkg::*;

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;
    localparam logic [AXW-1:0] LAST_AXIS = AXW'(AXES - 1);
    localparam int ACC_W = 36;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic [3:0] SP_LOAD   = 4'd0;
    localparam logic [3:0] SP_PROP   = 4'd1;
    localparam logic [3:0] SP_DERIV  = 4'd2;
    localparam logic [3:0] SP_SQUARE = 4'd3;
    localparam logic [3:0] SP_RECIP  = 4'd4;
    localparam logic [3:0] SP_BACK   = 4'd5;
    localparam logic [3:0] SP_CORR   = 4'd6;
    localparam logic [3:0] SP_SCALE  = 4'd7;
    localparam logic [3:0] SP_STEP   = 4'd8;
    localparam logic [3:0] SP_SUM    = 4'd9;
    localparam logic [3:0] SP_CLAMP  = 4'd10;

    localparam logic signed [PROD_W-1:0] ROUND_INC = 52'sd1048576;

    logic [1:0]               r_state;
    logic [3:0]               r_step;
    logic [AXW-1:0]           r_axis;
    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic signed [FIELD_W-1:0] r_integ [AXES];

    logic [IN_DATA_W-1:0]     r_in_data;
    logic                     r_grounded;
    logic [5:0]               r_flags;

    logic signed [16:0]       r_err;
    logic signed [16:0]       r_e;
    logic [12:0]              r_eabs;
    logic                     r_big;
    logic signed [ACC_W-1:0]  r_acc;
    logic [25:0]              r_e2;
    logic [15:0]              r_q0;
    logic [16:0]              r_q;
    logic signed [32:0]       r_ie;
    logic signed [30:0]       r_nv;
    logic signed [FIELD_W-1:0] r_wdrv [AXES];
    logic signed [FIELD_W-1:0] r_wint [AXES];

    t_gains                   w_gains;
    t_mul_op                  w_op;
    logic signed [PROD_W-1:0] w_prod;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_last;
    logic signed [FIELD_W-1:0] w_rate;
    logic signed [FIELD_W-1:0] w_target;
    logic signed [FIELD_W-1:0] w_accel;
    logic [FIELD_W-1:0]       w_dt;
    logic signed [FIELD_W-1:0] w_integ;
    logic                     w_pos_sat;
    logic                     w_neg_sat;
    logic signed [16:0]       w_err;
    logic signed [16:0]       w_elim;
    logic [16:0]              w_mag;
    logic signed [ACC_W-1:0]  w_round;
    logic [41:0]              w_rem;
    logic [16:0]              w_f;
    logic signed [PROD_W-1:0] w_sum;
    logic signed [30:0]       w_lim;
    logic signed [30:0]       w_clamp;
    logic signed [FIELD_W-1:0] w_new_integ;
    logic [OUT_DATA_W-1:0]    w_result;

    rpid_cfg #(
        .AXES (AXES)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .i_axis     (r_axis),
        .o_gains    (w_gains)
    );

    rpid_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (w_op),
        .o_prod (w_prod)
    );

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_last     = (r_axis == LAST_AXIS);

    assign w_rate    = $signed(r_in_data[FIELD_W*r_axis +: FIELD_W]);
    assign w_target  = $signed(r_in_data[FIELD_W*(NUM_AXES_MAX + r_axis) +: FIELD_W]);
    assign w_accel   = $signed(r_in_data[FIELD_W*(2*NUM_AXES_MAX + r_axis) +: FIELD_W]);
    assign w_dt      = r_in_data[IN_DATA_W-1 -: FIELD_W];
    assign w_integ   = r_integ[r_axis];
    assign w_pos_sat = r_flags[r_axis];
    assign w_neg_sat = r_flags[NUM_AXES_MAX + r_axis];

    always_comb begin
        w_err  = 17'(w_target) - 17'(w_rate);
        w_elim = w_err;
        if (w_pos_sat && (w_err > 17'sd0)) begin
            w_elim = '0;
        end
        if (w_neg_sat && (w_err < 17'sd0)) begin
            w_elim = '0;
        end
    end

    assign w_mag   = r_e[16] ? 17'(-r_e) : 17'(r_e);
    assign w_round = r_acc + 36'sd16;
    assign w_rem   = {r_e2, 16'd0} - w_prod[41:0];
    assign w_f     = r_big ? 17'd0 : (17'h10000 - r_q);
    assign w_sum   = w_prod + (PROD_W'(w_integ) <<< 21) + ROUND_INC;
    assign w_lim   = $signed({15'd0, w_gains.limit});

    always_comb begin
        if (r_nv > w_lim) begin
            w_clamp = w_lim;
        end else if (r_nv < -w_lim) begin
            w_clamp = -w_lim;
        end else begin
            w_clamp = r_nv;
        end
        w_new_integ = r_grounded ? w_integ : sat16(w_clamp);
    end

    always_comb begin
        w_op.a = '0;
        w_op.b = '0;
        case (r_step)
            SP_LOAD: begin
                w_op.a = MUL_A_W'(w_target);
                w_op.b = {2'b00, w_gains.ffwd};
            end
            SP_PROP: begin
                w_op.a = MUL_A_W'(r_err);
                w_op.b = {2'b00, w_gains.prop};
            end
            SP_DERIV: begin
                w_op.a = MUL_A_W'(w_accel);
                w_op.b = {2'b00, w_gains.deriv};
            end
            SP_SQUARE: begin
                w_op.a = {21'd0, r_eabs};
                w_op.b = {5'd0, r_eabs};
            end
            SP_RECIP: begin
                w_op.a = {8'd0, w_prod[25:0]};
                w_op.b = {1'b0, RECIP_K};
            end
            SP_BACK: begin
                w_op.a = {8'd0, RATE_LIM_SQ};
                w_op.b = {2'b00, w_prod[41:26]};
            end
            SP_CORR: begin
                w_op.a = MUL_A_W'(r_e);
                w_op.b = {2'b00, w_gains.integ};
            end
            SP_SCALE: begin
                w_op.a = {17'd0, w_f};
                w_op.b = {2'b00, w_dt};
            end
            SP_STEP: begin
                w_op.a = MUL_A_W'(r_ie);
                w_op.b = {2'b00, w_prod[31:16]};
            end
            default: ;
        endcase
    end

    generate
        for (genvar gi = 0; gi < NUM_AXES_MAX; gi++) begin : g_res
            if (gi < AXES) begin : g_on
                assign w_result[FIELD_W*gi +: FIELD_W] = r_wdrv[gi];
                assign w_result[FIELD_W*(NUM_AXES_MAX + gi) +: FIELD_W] = r_wint[gi];
            end else begin : g_off
                assign w_result[FIELD_W*gi +: FIELD_W] = '0;
                assign w_result[FIELD_W*(NUM_AXES_MAX + gi) +: FIELD_W] = '0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_WAIT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= SP_LOAD;
            r_axis      <= '0;
            for (int i = 0; i < AXES; i++) begin
                r_integ[i] <= '0;
            end
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= ST_RUN;
                        r_step  <= SP_LOAD;
                        r_axis  <= '0;
                    end
                end
                ST_RUN: begin
                    if (r_step == SP_CLAMP) begin
                        r_integ[r_axis] <= w_new_integ;
                        r_step          <= SP_LOAD;
                        if (w_last) begin
                            r_state <= ST_WAIT;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_WAIT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_data  <= i_s_axis_tdata;
            r_grounded <= i_s_axis_tuser[0];
            r_flags    <= i_s_axis_tuser[6:1];
        end
        if (w_out_free && (r_state == ST_WAIT)) begin
            r_out_data <= w_result;
        end
        if (r_state == ST_RUN) begin
            case (r_step)
                SP_LOAD: begin
                    r_err <= w_err;
                    r_e   <= w_elim;
                    r_acc <= $signed({{(ACC_W-21){w_integ[FIELD_W-1]}}, w_integ, 5'd0});
                end
                SP_PROP: begin
                    r_eabs <= w_mag[12:0];
                    r_big  <= (w_mag >= RATE_LIM);
                    r_acc  <= r_acc + ACC_W'(w_prod);
                end
                SP_DERIV: begin
                    r_acc <= r_acc + ACC_W'(w_prod);
                end
                SP_SQUARE: begin
                    r_acc <= r_acc - ACC_W'(w_prod);
                end
                SP_RECIP: begin
                    r_e2           <= w_prod[25:0];
                    r_wdrv[r_axis] <= sat16(w_round[ACC_W-1:5]);
                end
                SP_BACK: begin
                    r_q0 <= w_prod[41:26];
                end
                SP_CORR: begin
                    r_q <= {1'b0, r_q0} + 17'(w_rem >= {16'd0, RATE_LIM_SQ});
                end
                SP_SCALE: begin
                    r_ie <= w_prod[32:0];
                end
                SP_SUM: begin
                    r_nv <= $signed(w_sum[PROD_W-1:21]);
                end
                SP_CLAMP: begin
                    r_wint[r_axis] <= w_new_integ;
                end
                default: ;
            endcase
        end
    end

endmodule

// ===== rtl/core/rpid_chk.sv =====
// ============================================================================
// Rate PID port checker
// Handshake and busy-window properties seen at the top-level ports.
// ============================================================================
`include "three_axis_rate_pid_top_macros.svh"

module rpid_chk (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic [rpid_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    input logic [rpid_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [rpid_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    input logic                              i_cfg_valid,
    input logic                              o_cfg_ready,
    input logic [rpid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input logic [rpid_pkg::REG_W-1:0]        i_cfg_data
);

    `RPID_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid, "output word dropped while stalled")
    `RPID_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, $stable(o_m_axis_tdata), "output word changed while stalled")
    `RPID_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input ready while a word is in work")
    `RPID_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, $past(i_s_axis_tvalid && o_s_axis_tready), !$rose(o_m_axis_tvalid), "result appeared too soon after accept")

endmodule

bind three_axis_rate_pid_top rpid_chk u_rpid_chk (.*);

// ===== sim/tb_three_axis_rate_pid_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Three-axis rate PID testbench
// Drives control-step words with random gaps and random output stalls, and
// predicts every torque and integral word from a behavioral model of the
// P, I, D and feedforward paths with anti-windup. Each result is checked
// field by field. The gain and limit registers are rewritten between phases.
// ============================================================================
module tb_three_axis_rate_pid_top;

    localparam int      AXES         = 3;
    localparam longint  RATE_SQ      = 64'd7149 * 64'd7149;
    localparam int      IDLE_PCT     = 36;
    localparam int      STALL_LIMIT  = 5000;
    localparam int      PHASES       = 8;
    localparam int      PHASE_STEPS  = 229;

    typedef struct packed {
        logic [5:0]       sat_flags;
        logic             grounded;
        logic [15:0]      dt;
        logic [2:0][15:0] accel;
        logic [2:0][15:0] target;
        logic [2:0][15:0] rate;
    } rate_sample_t;

    typedef struct packed {
        logic [2:0][15:0] integ;
        logic [2:0][15:0] drive;
    } axis_cmd_t;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_s_axis_tvalid = 1'b0;
    logic                              o_s_axis_tready;
    // roll_rate, pitch_rate, yaw_rate, roll_target, pitch_target, yaw_target,
    // roll_accel, pitch_accel, yaw_accel, step_time
    logic [rpid_pkg::IN_DATA_W-1:0]    i_s_axis_tdata = '0;
    // on_ground, limit_flags
    logic [rpid_pkg::IN_USER_W-1:0]    i_s_axis_tuser = '0;
    logic                              o_m_axis_tvalid;
    logic                              i_m_axis_tready = 1'b0;
    // roll_drive, pitch_drive, yaw_drive, roll_integral, pitch_integral,
    // yaw_integral
    logic [rpid_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [rpid_pkg::CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [rpid_pkg::REG_W-1:0]        i_cfg_data = '0;

    logic [47:0]      gain_regs [rpid_pkg::NUM_REGS];
    logic [2:0][15:0] integ_state;
    axis_cmd_t        expected_cmds [$];
    string            axis_name [3] = '{"roll", "pitch", "yaw"};

    bit steady_run = 1'b0;
    int error_count = 0;
    int steps_sent = 0;
    int grounded_steps = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int stall_cycles = 0;

    three_axis_rate_pid_top #(
        .AXES(AXES)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_m_axis_tready <= steady_run || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint gain_field(input int idx, input int axis);
        return longint'(gain_regs[idx][16*axis +: 16]);
    endfunction

    function automatic longint round_down(input longint x, input int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [15:0] clip_word(input longint x);
        if (x > 32767) begin
            return 16'h7fff;
        end
        if (x < -32768) begin
            return 16'h8000;
        end
        return x[15:0];
    endfunction

    function automatic axis_cmd_t step_rate_model(input rate_sample_t s);
        axis_cmd_t r;
        int a;
        longint rate, tgt, acc, err, e, integ, sum, inc, lim, nv;
        longint unsigned q, f, fd;
        r = '0;
        for (a = 0; a < AXES; a++) begin
            rate  = longint'($signed(s.rate[a]));
            tgt   = longint'($signed(s.target[a]));
            acc   = longint'($signed(s.accel[a]));
            err   = tgt - rate;
            integ = longint'($signed(integ_state[a]));
            sum = gain_field(rpid_pkg::REG_PROP, a) * err
                - gain_field(rpid_pkg::REG_DERIV, a) * acc
                + gain_field(rpid_pkg::REG_FFWD, a) * tgt + integ * 32;
            r.drive[a] = clip_word(round_down(sum, 5));
            if (!s.grounded) begin
                e = err;
                if (s.sat_flags[a] && e > 0) begin
                    e = 0;
                end
                if (s.sat_flags[3 + a] && e < 0) begin
                    e = 0;
                end
                q  = (longint'(e * e) << 16) / RATE_SQ;
                f  = (q >= 65536) ? 0 : 65536 - q;
                fd = (f * longint'(s.dt)) >> 16;
                inc = round_down(gain_field(rpid_pkg::REG_INTEG, a) * e * longint'(fd), 21);
                lim = gain_field(rpid_pkg::REG_LIMIT, a);
                nv  = integ + inc;
                if (nv > lim) begin
                    nv = lim;
                end
                if (nv < -lim) begin
                    nv = -lim;
                end
                integ_state[a] = clip_word(nv);
            end
            r.integ[a] = integ_state[a];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin : check_results
        axis_cmd_t got, want;
        int a;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = o_m_axis_tdata;
            if (expected_cmds.size() == 0) begin
                flag_error($sformatf("unexpected result word %h", o_m_axis_tdata));
            end else begin
                want = expected_cmds.pop_front();
                for (a = 0; a < 3; a++) begin
                    if (got.drive[a] !== want.drive[a]) begin
                        flag_error($sformatf("result %0d %s drive: expected %0d, got %0d",
                            results_checked, axis_name[a], $signed(want.drive[a]),
                            $signed(got.drive[a])));
                    end
                    if (got.integ[a] !== want.integ[a]) begin
                        flag_error($sformatf("result %0d %s integral: expected %0d, got %0d",
                            results_checked, axis_name[a], $signed(want.integ[a]),
                            $signed(got.integ[a])));
                    end
                end
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic send_rate_step(input rate_sample_t s);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {s.dt, s.accel, s.target, s.rate};
        i_s_axis_tuser  <= {s.sat_flags, s.grounded};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        expected_cmds.push_back(step_rate_model(s));
        steps_sent++;
        if (s.grounded) begin
            grounded_steps++;
        end
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_gain_reg(input logic [2:0] idx, input logic [47:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx < rpid_pkg::NUM_REGS) begin
            gain_regs[idx] = val;
        end
        reg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [47:0] pack3(input int roll, input int pitch, input int yaw);
        return {16'(yaw), 16'(pitch), 16'(roll)};
    endfunction

    function automatic rate_sample_t uniform_sample(input int rate, input int tgt,
                                                    input int acc, input int dt,
                                                    input bit gnd, input logic [5:0] flags);
        rate_sample_t s;
        int a;
        for (a = 0; a < 3; a++) begin
            s.rate[a]   = 16'(rate);
            s.target[a] = 16'(tgt);
            s.accel[a]  = 16'(acc);
        end
        s.dt        = 16'(dt);
        s.grounded  = gnd;
        s.sat_flags = flags;
        return s;
    endfunction

    function automatic rate_sample_t rand_rate_step();
        rate_sample_t s;
        int a, v;
        bit wild;
        wild = ($urandom_range(0, 99) < 15);
        for (a = 0; a < 3; a++) begin
            if (wild) begin
                s.rate[a]   = 16'($urandom);
                s.target[a] = 16'($urandom);
                s.accel[a]  = 16'($urandom);
            end else begin
                v = $urandom_range(0, 16000) - 8000;
                s.rate[a] = v[15:0];
                v = v + $urandom_range(0, 5000) - 2500;
                s.target[a] = v[15:0];
                v = $urandom_range(0, 20000) - 10000;
                s.accel[a] = v[15:0];
            end
        end
        s.dt        = wild ? 16'($urandom) : 16'($urandom_range(0, 3000));
        s.grounded  = ($urandom_range(0, 99) < 8);
        s.sat_flags = ($urandom_range(0, 99) < 30) ? 6'($urandom) : 6'd0;
        return s;
    endfunction

    function automatic logic [47:0] rand_limit_word();
        logic [47:0] w;
        int a;
        for (a = 0; a < 3; a++) begin
            case ($urandom_range(0, 3))
                0:       w[16*a +: 16] = 16'd0;
                1:       w[16*a +: 16] = 16'hffff;
                default: w[16*a +: 16] = 16'($urandom_range(0, 16'h7fff));
            endcase
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_rate_step(uniform_sample(-32768, 32767, -32768, 65535, 1'b0, 6'd0));
        send_rate_step(uniform_sample(1234, -4321, 999, 3000, 1'b0, 6'b101010));
        drain_results();
    endtask

    task automatic test_register_decode();
        write_gain_reg(3'd5, 48'hffff_ffff_ffff);
        write_gain_reg(3'd6, 48'h1234_5678_9abc);
        write_gain_reg(3'd7, 48'h7fff_0001_8000);
        send_rate_step(uniform_sample(0, 3000, 2000, 20000, 1'b0, 6'd0));
        drain_results();
    endtask

    task automatic test_directed_cases();
        write_gain_reg(rpid_pkg::REG_PROP,  pack3(16'h0100, 16'h0200, 16'hffff));
        write_gain_reg(rpid_pkg::REG_INTEG, pack3(16'h0400, 16'hffff, 16'h0080));
        write_gain_reg(rpid_pkg::REG_DERIV, pack3(16'h0040, 16'hffff, 16'h0000));
        write_gain_reg(rpid_pkg::REG_FFWD,  pack3(16'h0080, 16'h0000, 16'hffff));
        write_gain_reg(rpid_pkg::REG_LIMIT, pack3(16'h1000, 16'hffff, 16'h0000));
        send_rate_step(uniform_sample(0, 0, 0, 0, 1'b0, 6'd0));
        send_rate_step(uniform_sample(-32768, 32767, -32768, 65535, 1'b0, 6'd0));
        send_rate_step(uniform_sample(32767, -32768, 32767, 65535, 1'b0, 6'd0));
        repeat (4) send_rate_step(uniform_sample(0, 1000, 0, 20000, 1'b0, 6'd0));
        send_rate_step(uniform_sample(0, 1000, 500, 20000, 1'b0, 6'b000111));
        send_rate_step(uniform_sample(1000, 0, -500, 20000, 1'b0, 6'b111000));
        send_rate_step(uniform_sample(1000, 0, 0, 20000, 1'b0, 6'b000111));
        send_rate_step(uniform_sample(0, 2000, 0, 30000, 1'b0, 6'b111111));
        send_rate_step(uniform_sample(0, 2000, 100, 30000, 1'b1, 6'd0));
        send_rate_step(uniform_sample(0, 7149, 0, 65535, 1'b0, 6'd0));
        send_rate_step(uniform_sample(0, 7148, 0, 65535, 1'b0, 6'd0));
        send_rate_step(uniform_sample(7149, 0, 0, 65535, 1'b0, 6'd0));
        drain_results();
    endtask

    task automatic test_limit_rewrite();
        write_gain_reg(rpid_pkg::REG_LIMIT, pack3(16'h0010, 16'h0010, 16'h0010));
        send_rate_step(uniform_sample(0, 500, 0, 10000, 1'b1, 6'd0));
        send_rate_step(uniform_sample(0, 0, 0, 10000, 1'b0, 6'd0));
        drain_results();
    endtask

    task automatic test_random_settings();
        int p, k;
        for (p = 0; p < PHASES; p++) begin
            steady_run = (p == 2);
            case (p)
                0: begin
                    for (k = 0; k < rpid_pkg::NUM_REGS; k++) begin
                        write_gain_reg(k[2:0], 48'hffff_ffff_ffff);
                    end
                end
                1: begin
                    write_gain_reg(rpid_pkg::REG_PROP,  48'd0);
                    write_gain_reg(rpid_pkg::REG_INTEG, 48'd0);
                    write_gain_reg(rpid_pkg::REG_DERIV, 48'd0);
                    write_gain_reg(rpid_pkg::REG_FFWD,  48'd0);
                    write_gain_reg(rpid_pkg::REG_LIMIT, rand_limit_word());
                end
                5: begin
                    for (k = 0; k < rpid_pkg::NUM_REGS; k++) begin
                        write_gain_reg(k[2:0], {16'($urandom), 32'($urandom)});
                    end
                end
                default: begin
                    write_gain_reg(rpid_pkg::REG_PROP, pack3($urandom_range(0, 16'h0800),
                        $urandom_range(0, 16'h0800), $urandom_range(0, 16'h0800)));
                    write_gain_reg(rpid_pkg::REG_INTEG, pack3($urandom_range(0, 16'h2000),
                        $urandom_range(0, 16'h2000), $urandom_range(0, 16'h2000)));
                    write_gain_reg(rpid_pkg::REG_DERIV, pack3($urandom_range(0, 16'h0200),
                        $urandom_range(0, 16'h0200), $urandom_range(0, 16'h0200)));
                    write_gain_reg(rpid_pkg::REG_FFWD, pack3($urandom_range(0, 16'h0400),
                        $urandom_range(0, 16'h0400), $urandom_range(0, 16'h0400)));
                    write_gain_reg(rpid_pkg::REG_LIMIT, rand_limit_word());
                end
            endcase
            write_gain_reg(3'(5 + p % 3), {16'($urandom), 32'($urandom)});
            for (k = 0; k < PHASE_STEPS; k++) begin
                send_rate_step(rand_rate_step());
            end
            drain_results();
        end
        steady_run = 1'b0;
    endtask

    initial begin : run_tests
        int k;
        for (k = 0; k < rpid_pkg::NUM_REGS; k++) begin
            gain_regs[k] = '0;
        end
        integ_state = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_decode();
        test_directed_cases();
        test_limit_rewrite();
        test_random_settings();

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("Ran %0d control steps (%0d grounded) through %0d register writes,",
                 steps_sent, grounded_steps, reg_writes);
        $display("checked %0d result words across %0d gain phases; %0d mismatches",
                 results_checked, PHASES + 1, error_count);
        if (error_count == 0 && expected_cmds.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
